/* src/dpcid_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the delta prefix-code image decoder.
// No dependencies; imported by delta_prefix_code_image_decoder.
package dpcid_pkg;

    localparam int DEF_MAX_CHANNELS    = 3;
    localparam int DEF_MAX_SUFFIX_BITS = 8;

    localparam int VALUE_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;
    localparam int LBITS_W   = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_THREE_CHANNELS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_MODE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_PIXEL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL0_BITS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL1_BITS    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL2_BITS    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL3_BITS    = 3'd7;

    // Register reset values.
    localparam logic [VALUE_W-1:0] RST_PIXEL_COUNT = 32'd1;
    localparam logic [LBITS_W-1:0] RST_LEVEL0_BITS = 4'd1;
    localparam logic [LBITS_W-1:0] RST_LEVEL1_BITS = 4'd2;
    localparam logic [LBITS_W-1:0] RST_LEVEL2_BITS = 4'd4;
    localparam logic [LBITS_W-1:0] RST_LEVEL3_BITS = 4'd8;

    typedef enum logic [1:0] {
        PS_FIRST  = 2'd0,
        PS_SECOND = 2'd1,
        PS_THIRD  = 2'd2,
        PS_SUFFIX = 2'd3
    } pstage_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BITS,
        ST_END,
        ST_TRUNC,
        ST_FLUSH
    } dec_state_t;

    // Two to the power of a suffix width, kept modulo 256.
    function automatic logic [7:0] pow2_mod256(input logic [LBITS_W-1:0] w);
        logic [7:0] r;
        r = 8'd0;
        if (w < 4'd8)
        begin
            r = 8'd1 << w;
        end
        return r;
    endfunction

endpackage

/* src/delta_prefix_code_image_decoder.sv */
`timescale 1ns / 1ps
// Top level of the delta prefix-code image decoder: bit-serial code parser,
// per-channel running values, a result hold stage and an output register.
// Depends on dpcid_pkg.
//
// Usage
// -----
// Compressed bytes enter on the input channel (in_valid / in_ready with
// code_byte and last_byte). Each accepted item is shifted through an 8-bit
// shift register and parsed one code bit per clock unless stalled, most
// significant bit first. Every completed code yields one sample on the
// output channel (out_valid / out_ready with sample, channel, last_of_run,
// image_done and truncated); an item can yield zero to eight samples plus
// one truncation result when the stream ends before the image is complete.
//
// Each input item passes through an accept state, one bit step of the
// serial parser per code bit (fewer once the image is done), an
// end-of-item state and a flush state that releases the held result with
// last_of_run set; a truncation result adds a state of its own. The next
// item is accepted only after the flush. Each result waits in a hold
// register until the next code of the same item completes or the item
// ends, so that it is known whether another result of the item follows.
//
// Stalls: when the output register is full and out_ready is low, a
// completed result waits in the hold stage, and once the hold stage is
// occupied the parser stops at the next bit until it can drain; nothing is
// dropped. A new item is accepted while a result still waits in the
// output register.
//
// Reset clears the control state and loads the register defaults; with a pixel
// count of one the image counts as done, so items produce no samples until
// configuration is written. Any register write restarts decoding, as does
// the end of an item marked last_byte.
module delta_prefix_code_image_decoder
    import dpcid_pkg::*;
#(
    parameter int MAX_CHANNELS    = DEF_MAX_CHANNELS,
    parameter int MAX_SUFFIX_BITS = DEF_MAX_SUFFIX_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           code_byte,
    input  logic                 last_byte,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           sample,
    output logic [1:0]           channel,
    output logic                 last_of_run,
    output logic                 image_done,
    output logic                 truncated
);

    localparam int SW       = MAX_SUFFIX_BITS;
    localparam int CH_IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam logic [1:0] CH_COLOR = (MAX_CHANNELS < 3) ? 2'(MAX_CHANNELS) : 2'd3;
    localparam logic [LBITS_W-1:0] MAX_W = LBITS_W'(MAX_SUFFIX_BITS);

    // Sequencer.
    dec_state_t state_reg, state_next;

    // Configuration registers.
    logic                 three_reg, three_next;
    logic                 view_reg, view_next;
    logic [VALUE_W-1:0]   pcount_reg, pcount_next;
    logic [23:0]          fpix_reg, fpix_next;
    logic [LBITS_W-1:0]   lbits_reg [4];
    logic [LBITS_W-1:0]   lbits_next [4];

    // Code parser and image position.
    pstage_t              pstage_reg, pstage_next;
    logic [1:0]           level_reg, level_next;
    logic [SW-1:0]        suf_reg, suf_next;
    logic [LBITS_W-1:0]   srem_reg, srem_next;
    logic [VALUE_W-1:0]   prev_reg [MAX_CHANNELS];
    logic [VALUE_W-1:0]   prev_next [MAX_CHANNELS];
    logic [1:0]           chan_reg, chan_next;
    logic [VALUE_W-1:0]   pix_reg, pix_next;
    logic                 fin_reg, fin_next;

    // Input shift register.
    logic [7:0]           sr_reg, sr_next;
    logic [2:0]           bcnt_reg, bcnt_next;
    logic                 last_reg, last_next;

    // Hold stage.
    logic                 h_valid_reg, h_valid_next;
    logic [7:0]           h_sample_reg, h_sample_next;
    logic [1:0]           h_chan_reg, h_chan_next;
    logic                 h_done_reg, h_done_next;
    logic                 h_trunc_reg, h_trunc_next;

    // Output register.
    logic                 o_valid_reg, o_valid_next;
    logic [7:0]           o_sample_reg, o_sample_next;
    logic [1:0]           o_chan_reg, o_chan_next;
    logic                 o_last_reg, o_last_next;
    logic                 o_done_reg, o_done_next;
    logic                 o_trunc_reg, o_trunc_next;

    // Combinational helpers.
    logic                 out_free;
    logic                 can_step;
    logic                 step_en;
    logic                 bit_in;
    logic [LBITS_W-1:0]   lw [4];
    logic [7:0]           offs [4];

    // Bit step results.
    pstage_t              st_pstage;
    logic [1:0]           st_level;
    logic [SW-1:0]        st_suf;
    logic [LBITS_W-1:0]   st_srem;
    logic                 st_done;

    // Code completion results.
    logic [7:0]           y;
    logic [8:0]           y_inc;
    logic [7:0]           mag;
    logic [1:0]           ch_eff;
    logic [CH_IDX_W-1:0]  ch_sel;
    logic [VALUE_W-1:0]   v_new;
    logic [9:0]           amp;
    logic [7:0]           smp;
    logic [1:0]           ch_total;
    logic [1:0]           chan_inc;
    logic [VALUE_W-1:0]   pix_inc;

    // Restart values.
    logic [VALUE_W-1:0]   rs_pc;
    logic [23:0]          rs_fp;

    assign out_free = !o_valid_reg || out_ready;
    assign can_step = !h_valid_reg || out_free;
    assign step_en  = (state_reg == ST_BITS) && !fin_reg && can_step;
    assign bit_in   = sr_reg[7];

    // Saturated level widths and cumulative level offsets modulo 256.
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            lw[k] = (lbits_reg[k] > MAX_W) ? MAX_W : lbits_reg[k];
        end
        offs[0] = 8'd0;
        offs[1] = pow2_mod256(lw[0]);
        offs[2] = offs[1] + pow2_mod256(lw[1]);
        offs[3] = offs[2] + pow2_mod256(lw[2]);
    end

    // One code bit through the prefix/suffix parser.
    always_comb
    begin
        st_pstage = pstage_reg;
        st_level  = level_reg;
        st_suf    = suf_reg;
        st_srem   = srem_reg;
        st_done   = 1'b0;
        unique case (pstage_reg)
            PS_SUFFIX:
            begin
                st_suf  = (suf_reg << 1) | SW'(bit_in);
                st_srem = srem_reg - 4'd1;
                st_done = (srem_reg == 4'd1);
            end
            PS_FIRST, PS_SECOND, PS_THIRD:
            begin
                if (pstage_reg == PS_FIRST && bit_in)
                begin
                    st_pstage = PS_SECOND;
                end
                else if (pstage_reg == PS_SECOND && bit_in)
                begin
                    st_pstage = PS_THIRD;
                end
                else
                begin
                    if (pstage_reg == PS_FIRST)
                    begin
                        st_level = 2'd0;
                    end
                    else if (pstage_reg == PS_SECOND)
                    begin
                        st_level = 2'd1;
                    end
                    else
                    begin
                        st_level = bit_in ? 2'd3 : 2'd2;
                    end
                    st_suf  = '0;
                    st_srem = lw[st_level];
                    if (lw[st_level] == 4'd0)
                    begin
                        st_done = 1'b1;
                    end
                    else
                    begin
                        st_pstage = PS_SUFFIX;
                    end
                end
            end
            default:
            begin
                st_pstage = pstage_reg;
            end
        endcase
    end

    // Sample for a completed code: zigzag delta, running value, output map.
    always_comb
    begin
        y      = offs[st_level] + 8'(st_suf);
        y_inc  = {1'b0, y} + 9'd1;
        mag    = y[0] ? y_inc[8:1] : {1'b0, y[7:1]};
        ch_eff = (32'(chan_reg) >= 32'(MAX_CHANNELS)) ? 2'd0 : chan_reg;
        ch_sel = CH_IDX_W'(ch_eff);
        if (y[0])
        begin
            v_new = prev_reg[ch_sel] - VALUE_W'(mag);
        end
        else
        begin
            v_new = prev_reg[ch_sel] + VALUE_W'(mag);
        end
        amp = {mag, 2'b00};
        if (view_reg)
        begin
            smp = (amp >= 10'd255) ? 8'd0 : 8'(10'd255 - amp);
        end
        else if (v_new[VALUE_W-1])
        begin
            smp = 8'd0;
        end
        else if (v_new > VALUE_W'(127))
        begin
            smp = 8'd255;
        end
        else
        begin
            smp = {v_new[6:0], 1'b0};
        end
        ch_total = three_reg ? CH_COLOR : 2'd1;
        chan_inc = chan_reg + 2'd1;
        pix_inc  = pix_reg + VALUE_W'(1);
    end

    // Restart values take a register that is being written this cycle.
    assign rs_pc = (cfg_we && cfg_index == REG_PIXEL_COUNT) ? cfg_data : pcount_reg;
    assign rs_fp = (cfg_we && cfg_index == REG_FIRST_PIXEL) ? cfg_data[23:0] : fpix_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_BITS;
                end
            end
            ST_BITS:
            begin
                if (fin_reg || (step_en && bcnt_reg == 3'd0))
                begin
                    state_next = ST_END;
                end
            end
            ST_END:
            begin
                state_next = (last_reg && !fin_reg) ? ST_TRUNC : ST_FLUSH;
            end
            ST_TRUNC:
            begin
                if (can_step)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (can_step)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);

    // Datapath and handshake outputs.
    always_comb
    begin
        three_next = three_reg;
        view_next  = view_reg;
        pcount_next = pcount_reg;
        fpix_next  = fpix_reg;
        for (int k = 0; k < 4; k++)
        begin
            lbits_next[k] = lbits_reg[k];
        end
        pstage_next = pstage_reg;
        level_next  = level_reg;
        suf_next    = suf_reg;
        srem_next   = srem_reg;
        for (int c = 0; c < MAX_CHANNELS; c++)
        begin
            prev_next[c] = prev_reg[c];
        end
        chan_next = chan_reg;
        pix_next  = pix_reg;
        fin_next  = fin_reg;
        sr_next   = sr_reg;
        bcnt_next = bcnt_reg;
        last_next = last_reg;
        h_valid_next  = h_valid_reg;
        h_sample_next = h_sample_reg;
        h_chan_next   = h_chan_reg;
        h_done_next   = h_done_reg;
        h_trunc_next  = h_trunc_reg;
        o_valid_next  = o_valid_reg && !out_ready;
        o_sample_next = o_sample_reg;
        o_chan_next   = o_chan_reg;
        o_last_next   = o_last_reg;
        o_done_next   = o_done_reg;
        o_trunc_next  = o_trunc_reg;

        if (in_valid && in_ready)
        begin
            sr_next   = code_byte;
            bcnt_next = 3'd7;
            last_next = last_byte;
        end

        if (step_en)
        begin
            sr_next     = {sr_reg[6:0], 1'b0};
            bcnt_next   = bcnt_reg - 3'd1;
            pstage_next = st_pstage;
            level_next  = st_level;
            suf_next    = st_suf;
            srem_next   = st_srem;
            if (st_done)
            begin
                pstage_next = PS_FIRST;
                level_next  = 2'd0;
                suf_next    = '0;
                srem_next   = '0;
                prev_next[ch_sel] = v_new;
                // Earlier result of this item leaves the hold stage.
                if (h_valid_reg)
                begin
                    o_valid_next  = 1'b1;
                    o_sample_next = h_sample_reg;
                    o_chan_next   = h_chan_reg;
                    o_last_next   = 1'b0;
                    o_done_next   = h_done_reg;
                    o_trunc_next  = h_trunc_reg;
                end
                h_valid_next  = 1'b1;
                h_sample_next = smp;
                h_chan_next   = chan_reg;
                h_trunc_next  = 1'b0;
                h_done_next   = 1'b0;
                if (chan_inc >= ch_total)
                begin
                    chan_next = 2'd0;
                    pix_next  = pix_inc;
                    if (pix_inc >= pcount_reg)
                    begin
                        fin_next    = 1'b1;
                        h_done_next = 1'b1;
                    end
                end
                else
                begin
                    chan_next = chan_inc;
                end
            end
        end

        if (state_reg == ST_TRUNC && can_step)
        begin
            if (h_valid_reg)
            begin
                o_valid_next  = 1'b1;
                o_sample_next = h_sample_reg;
                o_chan_next   = h_chan_reg;
                o_last_next   = 1'b0;
                o_done_next   = h_done_reg;
                o_trunc_next  = h_trunc_reg;
            end
            h_valid_next  = 1'b1;
            h_sample_next = 8'd0;
            h_chan_next   = chan_reg;
            h_done_next   = 1'b0;
            h_trunc_next  = 1'b1;
        end

        if (state_reg == ST_FLUSH && can_step && h_valid_reg)
        begin
            o_valid_next  = 1'b1;
            o_sample_next = h_sample_reg;
            o_chan_next   = h_chan_reg;
            o_last_next   = 1'b1;
            o_done_next   = h_done_reg;
            o_trunc_next  = h_trunc_reg;
            h_valid_next  = 1'b0;
        end

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_THREE_CHANNELS: three_next  = cfg_data[0];
                REG_VIEW_MODE:      view_next   = cfg_data[0];
                REG_PIXEL_COUNT:    pcount_next = cfg_data;
                REG_FIRST_PIXEL:    fpix_next   = cfg_data[23:0];
                REG_LEVEL0_BITS:    lbits_next[0] = cfg_data[LBITS_W-1:0];
                REG_LEVEL1_BITS:    lbits_next[1] = cfg_data[LBITS_W-1:0];
                REG_LEVEL2_BITS:    lbits_next[2] = cfg_data[LBITS_W-1:0];
                REG_LEVEL3_BITS:    lbits_next[3] = cfg_data[LBITS_W-1:0];
                default:            three_next  = three_reg;
            endcase
        end

        // A register write, or the end of a final item, starts a new image.
        if (cfg_we || (state_reg == ST_FLUSH && can_step && last_reg))
        begin
            pstage_next = PS_FIRST;
            level_next  = 2'd0;
            suf_next    = '0;
            srem_next   = '0;
            chan_next   = 2'd0;
            pix_next    = VALUE_W'(1);
            fin_next    = (rs_pc <= VALUE_W'(1));
            for (int c = 0; c < MAX_CHANNELS; c++)
            begin
                prev_next[c] = (c < 3) ? VALUE_W'(rs_fp[8*(c%3) +: 8]) : '0;
            end
        end
    end

    // Control state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            three_reg   <= 1'b0;
            view_reg    <= 1'b0;
            pcount_reg  <= RST_PIXEL_COUNT;
            fpix_reg    <= '0;
            lbits_reg[0] <= RST_LEVEL0_BITS;
            lbits_reg[1] <= RST_LEVEL1_BITS;
            lbits_reg[2] <= RST_LEVEL2_BITS;
            lbits_reg[3] <= RST_LEVEL3_BITS;
            pstage_reg  <= PS_FIRST;
            level_reg   <= 2'd0;
            suf_reg     <= '0;
            srem_reg    <= '0;
            for (int c = 0; c < MAX_CHANNELS; c++)
            begin
                prev_reg[c] <= '0;
            end
            chan_reg    <= 2'd0;
            pix_reg     <= VALUE_W'(1);
            fin_reg     <= 1'b1;
            bcnt_reg    <= 3'd0;
            h_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            three_reg   <= three_next;
            view_reg    <= view_next;
            pcount_reg  <= pcount_next;
            fpix_reg    <= fpix_next;
            for (int k = 0; k < 4; k++)
            begin
                lbits_reg[k] <= lbits_next[k];
            end
            pstage_reg  <= pstage_next;
            level_reg   <= level_next;
            suf_reg     <= suf_next;
            srem_reg    <= srem_next;
            for (int c = 0; c < MAX_CHANNELS; c++)
            begin
                prev_reg[c] <= prev_next[c];
            end
            chan_reg    <= chan_next;
            pix_reg     <= pix_next;
            fin_reg     <= fin_next;
            bcnt_reg    <= bcnt_next;
            h_valid_reg <= h_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        sr_reg       <= sr_next;
        last_reg     <= last_next;
        h_sample_reg <= h_sample_next;
        h_chan_reg   <= h_chan_next;
        h_done_reg   <= h_done_next;
        h_trunc_reg  <= h_trunc_next;
        o_sample_reg <= o_sample_next;
        o_chan_reg   <= o_chan_next;
        o_last_reg   <= o_last_next;
        o_done_reg   <= o_done_next;
        o_trunc_reg  <= o_trunc_next;
    end

    assign out_valid   = o_valid_reg;
    assign sample      = o_sample_reg;
    assign channel     = o_chan_reg;
    assign last_of_run = o_last_reg;
    assign image_done  = o_done_reg;
    assign truncated   = o_trunc_reg;

    // The hold stage is always drained before a new item is taken.
    a_hold_empty_at_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !h_valid_reg)
        else $error("hold stage still full while accepting an item");

    // A truncation result closes its item and never marks the image done.
    a_trunc_closes_item: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && truncated) |-> (last_of_run && !image_done))
        else $error("truncation result without last_of_run or with image_done");

    // Once the image is done, the rest of an item is skipped at once.
    a_skip_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BITS && fin_reg) |=> (state_reg == ST_END))
        else $error("parser kept running after the final sample");

    // The channel counter never reaches three.
    a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (channel != 2'd3))
        else $error("result carries an out-of-range channel");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for delta_prefix_code_image_decoder: a scoreboard class
// predicts every decoded sample, and plain tasks drive the item channels.
// Depends on dpcid_pkg and the decoder RTL.
module tb_top;
    import dpcid_pkg::*;

    // Pause after the last expected result before a register write or the end.
    localparam int SETTLE_CYCLES  = 30;
    // Long receiver hold-off that makes the decoder fill up and stall its input.
    localparam int LONG_HOLD      = 400;
    // Cycles with no item accepted on either side before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 3000;
    // The stimulus starts no new phase once this many bytes have been sent.
    localparam int BYTE_TARGET    = 290;

    // One decoded result as it appears on the output channel.
    typedef struct {
        logic [7:0] sample;
        logic [1:0] channel;
        logic       last_of_run;
        logic       image_done;
        logic       truncated;
    } sample_rec_t;

    // The scoreboard keeps its own copy of the registers and of the decoder
    // state, decodes every accepted byte bit by bit, and queues the samples
    // that the byte must produce.
    class sample_scoreboard;
        logic                three_ch;
        logic                view;
        logic [31:0]         pix_count;
        logic [23:0]         first_pix;
        logic [LBITS_W-1:0]  lvl_bits [4];

        pstage_t             stage;
        logic [1:0]          lvl;
        logic [7:0]          suf_val;
        logic [3:0]          suf_rem;
        logic [31:0]         running [3];
        logic [1:0]          ch_idx;
        logic [31:0]         pix_idx;
        logic                finished;

        sample_rec_t         pending_samples [$];
        int                  errors;

        function new();
            three_ch  = 1'b0;
            view      = 1'b0;
            pix_count = RST_PIXEL_COUNT;
            first_pix = '0;
            lvl_bits[0] = RST_LEVEL0_BITS;
            lvl_bits[1] = RST_LEVEL1_BITS;
            lvl_bits[2] = RST_LEVEL2_BITS;
            lvl_bits[3] = RST_LEVEL3_BITS;
            errors = 0;
            reload_image();
        endfunction

        // Widths above the suffix limit saturate, for reading and for offsets.
        function int unsigned level_width(int unsigned l);
            int unsigned w;
            w = lvl_bits[l];
            return (w > DEF_MAX_SUFFIX_BITS) ? DEF_MAX_SUFFIX_BITS : w;
        endfunction

        function int unsigned channel_count();
            int unsigned n;
            n = three_ch ? 3 : 1;
            return (n > DEF_MAX_CHANNELS) ? DEF_MAX_CHANNELS : n;
        endfunction

        function void reload_image();
            stage    = PS_FIRST;
            lvl      = '0;
            suf_val  = '0;
            suf_rem  = '0;
            ch_idx   = '0;
            pix_idx  = 32'd1;
            for (int c = 0; c < 3; c++)
            begin
                running[c] = {24'd0, first_pix[8*c +: 8]};
            end
            finished = (pix_count <= 32'd1);
        endfunction

        // Any register write starts a new image.
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_THREE_CHANNELS: three_ch  = data[0];
                REG_VIEW_MODE:      view      = data[0];
                REG_PIXEL_COUNT:    pix_count = data;
                REG_FIRST_PIXEL:    first_pix = data[23:0];
                REG_LEVEL0_BITS:    lvl_bits[0] = data[LBITS_W-1:0];
                REG_LEVEL1_BITS:    lvl_bits[1] = data[LBITS_W-1:0];
                REG_LEVEL2_BITS:    lvl_bits[2] = data[LBITS_W-1:0];
                default:            lvl_bits[3] = data[LBITS_W-1:0];
            endcase
            reload_image();
        endfunction

        // Completes the current code: updates the channel value and returns
        // the sample, either the doubled clamped value or the difference view.
        function logic [7:0] close_code();
            int unsigned off;
            logic [7:0]  y;
            int unsigned mag;
            int unsigned a;
            logic [31:0] v;
            logic [31:0] clamped;
            logic [7:0]  smp;
            off = 0;
            for (int unsigned k = 0; k < lvl; k++)
            begin
                off += 1 << level_width(k);
            end
            y = 8'(off + suf_val);
            // Zigzag unfolding: odd codes are negative deltas.
            mag = y[0] ? ((int'(y) + 1) >> 1) : (int'(y) >> 1);
            if (y[0])
            begin
                v = running[ch_idx] - mag;
            end
            else
            begin
                v = running[ch_idx] + mag;
            end
            running[ch_idx] = v;
            if (view)
            begin
                a = mag * 4;
                smp = (a >= 255) ? 8'd0 : 8'(255 - a);
            end
            else
            begin
                clamped = v[31] ? 32'd0 : ((v > 32'd255) ? 32'd255 : v);
                clamped = clamped << 1;
                smp = (clamped > 32'd255) ? 8'd255 : clamped[7:0];
            end
            stage   = PS_FIRST;
            lvl     = '0;
            suf_val = '0;
            suf_rem = '0;
            return smp;
        endfunction

        // Notes one accepted byte and queues the results it causes.
        function void decode_byte(logic [7:0] code, logic last);
            int          first;
            logic        bt;
            logic        done_code;
            logic        chosen;
            sample_rec_t rec;
            first = pending_samples.size();
            for (int i = 7; i >= 0 && !finished; i--)
            begin
                bt = code[i];
                done_code = 1'b0;
                if (stage == PS_SUFFIX)
                begin
                    suf_val = {suf_val[6:0], bt};
                    suf_rem = suf_rem - 4'd1;
                    done_code = (suf_rem == 4'd0);
                end
                else
                begin
                    chosen = 1'b1;
                    case (stage)
                        PS_FIRST:
                        begin
                            if (bt)
                            begin
                                stage = PS_SECOND;
                                chosen = 1'b0;
                            end
                            else
                            begin
                                lvl = 2'd0;
                            end
                        end
                        PS_SECOND:
                        begin
                            if (bt)
                            begin
                                stage = PS_THIRD;
                                chosen = 1'b0;
                            end
                            else
                            begin
                                lvl = 2'd1;
                            end
                        end
                        default:
                        begin
                            lvl = bt ? 2'd3 : 2'd2;
                        end
                    endcase
                    if (chosen)
                    begin
                        suf_val = '0;
                        suf_rem = 4'(level_width(lvl));
                        // A zero-width level ends its code on the last prefix bit.
                        if (suf_rem == 4'd0)
                        begin
                            done_code = 1'b1;
                        end
                        else
                        begin
                            stage = PS_SUFFIX;
                        end
                    end
                end
                if (done_code)
                begin
                    rec.channel     = ch_idx;
                    rec.sample      = close_code();
                    rec.last_of_run = 1'b0;
                    rec.image_done  = 1'b0;
                    rec.truncated   = 1'b0;
                    ch_idx = ch_idx + 2'd1;
                    if (ch_idx >= channel_count())
                    begin
                        ch_idx  = '0;
                        pix_idx = pix_idx + 32'd1;
                        if (pix_idx >= pix_count)
                        begin
                            finished = 1'b1;
                            rec.image_done = 1'b1;
                        end
                    end
                    pending_samples.push_back(rec);
                end
            end
            if (last)
            begin
                // A stream that stops short of the image gets a truncation result.
                if (!finished)
                begin
                    rec.sample      = 8'd0;
                    rec.channel     = ch_idx;
                    rec.last_of_run = 1'b0;
                    rec.image_done  = 1'b0;
                    rec.truncated   = 1'b1;
                    pending_samples.push_back(rec);
                end
                reload_image();
            end
            if (pending_samples.size() > first)
            begin
                pending_samples[pending_samples.size() - 1].last_of_run = 1'b1;
            end
        endfunction

        // Checks one accepted result against the oldest queued sample.
        function void compare_sample(logic [7:0] smp, logic [1:0] ch, logic lor,
                                     logic done, logic trunc);
            sample_rec_t want;
            if (pending_samples.size() == 0)
            begin
                $error("unexpected result: sample %0d channel %0d", smp, ch);
                errors++;
                return;
            end
            want = pending_samples.pop_front();
            if (smp !== want.sample)
            begin
                $error("sample: expected %0d, got %0d", want.sample, smp);
                errors++;
            end
            if (ch !== want.channel)
            begin
                $error("channel: expected %0d, got %0d", want.channel, ch);
                errors++;
            end
            if (lor !== want.last_of_run)
            begin
                $error("last_of_run: expected %0b, got %0b", want.last_of_run, lor);
                errors++;
            end
            if (done !== want.image_done)
            begin
                $error("image_done: expected %0b, got %0b", want.image_done, done);
                errors++;
            end
            if (trunc !== want.truncated)
            begin
                $error("truncated: expected %0b, got %0b", want.truncated, trunc);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [7:0]           code_byte;
    logic                 last_byte;
    logic                 out_valid;
    logic                 out_ready;
    logic [7:0]           sample;
    logic [1:0]           channel;
    logic                 last_of_run;
    logic                 image_done;
    logic                 truncated;

    sample_scoreboard     sb;
    int                   bytes_sent;
    bit                   no_idle;
    bit                   hold_off_req;
    int                   quiet_cycles;

    delta_prefix_code_image_decoder DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .code_byte   (code_byte),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .sample      (sample),
        .channel     (channel),
        .last_of_run (last_of_run),
        .image_done  (image_done),
        .truncated   (truncated)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Every task below is entered and left at a falling edge, which is
    // where all inputs of the decoder change.

    // Offers one byte as an item and waits until it is accepted. With no
    // gap the valid line simply stays high for the new item.
    task automatic send_byte(input logic [7:0] code, input logic last);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        code_byte <= code;
        last_byte <= last;
        do
        begin
            @(posedge clk);
        end
        while (in_ready !== 1'b1);
        sb.decode_byte(code, last);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Builds a well-formed code stream of the given number of codes with random
    // levels and suffixes, pads it to whole bytes, appends padding bytes and
    // sends it with the last byte marked.
    task automatic send_image(input int unsigned codes, input int unsigned pad_bytes);
        bit          stream_bits [$];
        int unsigned l;
        int unsigned nbytes;
        logic [7:0]  code;
        for (int unsigned k = 0; k < codes; k++)
        begin
            l = $urandom_range(0, 3);
            case (l)
                0: stream_bits.push_back(1'b0);
                1: begin stream_bits.push_back(1'b1); stream_bits.push_back(1'b0); end
                2:
                begin
                    stream_bits.push_back(1'b1);
                    stream_bits.push_back(1'b1);
                    stream_bits.push_back(1'b0);
                end
                default:
                begin
                    repeat (3) stream_bits.push_back(1'b1);
                end
            endcase
            repeat (sb.level_width(l)) stream_bits.push_back(1'($urandom_range(0, 1)));
        end
        while (stream_bits.size() == 0 || stream_bits.size() % 8 != 0)
        begin
            stream_bits.push_back(1'($urandom_range(0, 1)));
        end
        repeat (pad_bytes * 8) stream_bits.push_back(1'($urandom_range(0, 1)));
        nbytes = stream_bits.size() / 8;
        for (int unsigned j = 0; j < nbytes; j++)
        begin
            for (int i = 7; i >= 0; i--)
            begin
                code[i] = stream_bits.pop_front();
            end
            send_byte(code, j == nbytes - 1);
        end
    endtask

    // Random bytes, with the end-of-stream mark also set at random inside.
    task automatic send_noise();
        int unsigned n;
        n = $urandom_range(1, 4);
        for (int unsigned j = 0; j < n; j++)
        begin
            send_byte(8'($urandom), (j == n - 1) || ($urandom_range(0, 7) == 0));
        end
    endtask

    // Writes one register. Bits above the register's width carry random
    // garbage, which the decoder must ignore.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        logic [CFG_W-1:0] mask;
        logic [CFG_W-1:0] data;
        case (idx)
            REG_THREE_CHANNELS, REG_VIEW_MODE: mask = 32'h0000_0001;
            REG_PIXEL_COUNT:                   mask = 32'hFFFF_FFFF;
            REG_FIRST_PIXEL:                   mask = 32'h00FF_FFFF;
            default:                           mask = 32'h0000_000F;
        endcase
        data = ($urandom & ~mask) | (value & mask);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic program_config(input logic three, input logic view, input logic [31:0] count,
                                  input logic [23:0] first, input logic [3:0] w0,
                                  input logic [3:0] w1, input logic [3:0] w2,
                                  input logic [3:0] w3);
        write_register(REG_THREE_CHANNELS, {31'd0, three});
        write_register(REG_VIEW_MODE, {31'd0, view});
        write_register(REG_PIXEL_COUNT, count);
        write_register(REG_FIRST_PIXEL, {8'd0, first});
        write_register(REG_LEVEL0_BITS, {28'd0, w0});
        write_register(REG_LEVEL1_BITS, {28'd0, w1});
        write_register(REG_LEVEL2_BITS, {28'd0, w2});
        write_register(REG_LEVEL3_BITS, {28'd0, w3});
    endtask

    // Lowers valid, waits for every queued sample, then gives the decoder
    // time to finish a byte that produces nothing more.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending_samples.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Receiver: a random stall before each result, or one long hold-off when
    // the stimulus asks for it.
    initial
    begin
        int unsigned stall;
        out_ready = 1'b0;
        @(negedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else
            begin
                stall = no_idle ? 0 : $urandom_range(0, 11);
                if (stall != 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
            out_ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (out_valid !== 1'b1);
            sb.compare_sample(sample, channel, last_of_run, image_done, truncated);
            @(negedge clk);
        end
    end

    // Watchdog: ends a run in which no item moves on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((in_valid === 1'b1 && in_ready === 1'b1) ||
                (out_valid === 1'b1 && out_ready === 1'b1))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Main stimulus: directed cases first, then random configuration phases,
    // each followed by a few images of mixed kinds.
    initial
    begin
        int unsigned phase;
        int unsigned sel;
        int unsigned kind;
        int unsigned full;
        logic [31:0] count;
        sb           = new();
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        code_byte    = '0;
        last_byte    = 1'b0;
        bytes_sent   = 0;
        no_idle      = 1'b0;
        hold_off_req = 1'b0;
        quiet_cycles = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // After reset the pixel count is one, so the image is already done
        // and bytes, including the end of stream, produce nothing.
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        settle();

        // A pixel count of zero behaves like one.
        write_register(REG_PIXEL_COUNT, 32'd0);
        send_byte(8'hA5, 1'b1);
        settle();

        // Gray image at the default widths: runs of the shortest code, then
        // the longest code, then an early end of stream.
        program_config(1'b0, 1'b0, 32'd9, 24'h000000, 4'd1, 4'd2, 4'd4, 4'd8);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        settle();

        // Color view mode with zero-width levels: each prefix alone is a code.
        program_config(1'b1, 1'b1, 32'd4, 24'hFFFFFF, 4'd0, 4'd0, 4'd0, 4'd0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        settle();

        // Level widths beyond the suffix limit saturate; a pixel count this
        // large can only end by truncation.
        program_config(1'b0, 1'b0, 32'hFFFE_0001, 24'h00FF00, 4'd15, 4'd15, 4'd15, 4'd15);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b1);
        settle();

        // Full-width suffixes, a complete color image followed by padding
        // bytes, then an image left open that the next write must restart.
        program_config(1'b1, 1'b0, 32'd2, 24'h80FF01, 4'd8, 4'd8, 4'd8, 4'd8);
        send_image(3, 2);
        send_byte(8'hC3, 1'b0);

        phase = 0;
        while (bytes_sent < BYTE_TARGET)
        begin
            settle();
            no_idle = ($urandom_range(0, 4) == 0);
            sel = $urandom_range(0, 19);
            case (sel)
                0:       count = 32'd0;
                1:       count = 32'd1;
                2:       count = 32'hFFFE_0001;
                3:       count = $urandom_range(200, 32'hFFFE_0001);
                default: count = $urandom_range(2, 9);
            endcase
            if (phase == 3)
            begin
                count = 32'hFFFE_0001;
            end
            program_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), count,
                           24'($urandom_range(0, 24'hFFFFFF)),
                           4'($urandom_range(0, 8)), 4'($urandom_range(0, 8)),
                           4'($urandom_range(0, 8)), 4'($urandom_range(0, 8)));
            if (phase == 3)
            begin
                // The receiver holds off while a long stream keeps coming.
                hold_off_req = 1'b1;
                send_image(60, 0);
            end
            repeat ($urandom_range(2, 4))
            begin
                kind = $urandom_range(0, 9);
                full = (count <= 32'd1) ? 0 : (count - 1) * sb.channel_count();
                if (kind == 8)
                begin
                    send_noise();
                end
                else if (count > 32'd40)
                begin
                    send_image($urandom_range(1, 30), 0);
                end
                else if (kind == 7 && full > 0)
                begin
                    send_image($urandom_range(0, full - 1), 0);
                end
                else
                begin
                    send_image(full, (kind == 9) ? $urandom_range(1, 3) : 0);
                end
            end
            phase++;
        end

        in_valid <= 1'b0;
        while (sb.pending_samples.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.pending_samples.size() != 0)
        begin
            $error("%0d expected results never arrived", sb.pending_samples.size());
            sb.errors++;
        end
        if (sb.errors == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/dpcid_pkg.sv
src/delta_prefix_code_image_decoder.sv
sim/tb_top.sv
